/* design/ray_differential_uv_solver_macros.svh */
// Assertion macros used by the solver top level.
`ifndef RAY_DIFFERENTIAL_UV_SOLVER_MACROS_SVH
`define RAY_DIFFERENTIAL_UV_SOLVER_MACROS_SVH

// The antecedent must always be followed by the consequent on the next cycle.
`define RDUV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define RDUV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/rduv_pkg.sv */
package rduv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SLOT_W = 3;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] DET_THRESHOLD_RST = 32'd42950;

    localparam logic [SLOT_W-1:0] SLOT_NORMAL = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_HIT    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_DPDU   = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_DPDV   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_XORG   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_XDIR   = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_YORG   = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_YDIR   = 3'd7;

    // Operations that the controller issues to the datapath, one per step.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_AXIS,      // pick the axis pair from the normal
        OP_ND_HIT,    // acc = dot(n, hit)
        OP_ND_XORG,   // acc -= dot(n, x origin)
        OP_ND_XDIR,   // den = dot(n, x dir)
        OP_DIV_X,     // start t_x = acc / den
        OP_XP0,       // offset on axis 0 for x ray
        OP_XP1,
        OP_ND_HIT2,
        OP_ND_YORG,
        OP_ND_YDIR,
        OP_DIV_Y,
        OP_YP0,
        OP_YP1,
        OP_DET,       // det from dp/du, dp/dv
        OP_NUM0,      // numerator then divide, four times
        OP_NUM1,
        OP_NUM2,
        OP_NUM3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start_div;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic den_zero;
        logic det_small;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [95:0] hi;
        logic signed [95:0] lo;
        hi = 96'sh7FFF_FFFF;
        lo = -96'sh8000_0000;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

/* design/rduv_if.sv */
interface rduv_in_if;
    logic valid;
    logic ready;
    logic [2:0] slot;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    modport source (output valid, slot, comp_x, comp_y, comp_z, input ready);
    modport sink (input valid, slot, comp_x, comp_y, comp_z, output ready);
endinterface

interface rduv_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] du_dx;
    logic signed [31:0] dv_dx;
    logic signed [31:0] du_dy;
    logic signed [31:0] dv_dy;
    logic solved;
    modport source (output valid, du_dx, dv_dx, du_dy, dv_dy, solved, input ready);
    modport sink (input valid, du_dx, dv_dx, du_dy, dv_dy, solved, output ready);
endinterface

interface rduv_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* design/rduv_div.sv */
// Restoring divider: trunc(|num| * 2^FRAC / |den|), saturated to 32 bits with sign.
// One quotient bit per cycle over the integer and fraction bits of a wide quotient.
module rduv_div #(
    parameter int FRAC_BITS = rduv_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [95:0] num,
    input  logic signed [95:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);
    localparam int STEPS = 96 + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [95+FRAC_BITS:0] rem_sh_reg, rem_sh_next;
    logic [96:0] part_reg, part_next;
    logic [95:0] dv_reg, dv_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic busy_reg, busy_next;
    logic [96:0] trial;
    logic [95:0] anum, aden;
    logic [32:0] qmag;

    always_comb
    begin
        anum = num[95] ? 96'(-num) : 96'(num);
        aden = den[95] ? 96'(-den) : 96'(den);
        rem_sh_next = rem_sh_reg;
        part_next = part_reg;
        dv_next = dv_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        trial = {part_reg[95:0], rem_sh_reg[95+FRAC_BITS]} - {1'b0, dv_reg};
        if (start)
        begin
            rem_sh_next = {anum, {FRAC_BITS{1'b0}}};
            part_next = '0;
            dv_next = aden;
            cnt_next = CNT_W'(STEPS);
            neg_next = num[95] ^ den[95];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Quotient bits shift into the low end of rem_sh as dividend bits leave.
            if (!trial[96])
            begin
                part_next = trial;
                rem_sh_next = {rem_sh_reg[94+FRAC_BITS:0], 1'b1};
            end
            else
            begin
                part_next = {part_reg[95:0], rem_sh_reg[95+FRAC_BITS]};
                rem_sh_next = {rem_sh_reg[94+FRAC_BITS:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_sh_reg <= rem_sh_next;
        part_reg <= part_next;
        dv_reg <= dv_next;
        neg_reg <= neg_next;
    end

    // Once done, rem_sh holds the whole quotient; any bit above 32 saturates it.
    always_comb
    begin
        qmag = (rem_sh_reg[95+FRAC_BITS:33] != '0) ? 33'h1_0000_0000 : rem_sh_reg[32:0];
        if (neg_reg)
            quo = (qmag >= 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-qmag);
        else
            quo = (qmag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : qmag[31:0];
    end

    assign busy = busy_reg;
endmodule

/* design/rduv_datapath.sv */
module rduv_datapath #(
    parameter int FRAC_BITS = rduv_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_slot,
    input  logic signed [31:0] wr_x,
    input  logic signed [31:0] wr_y,
    input  logic signed [31:0] wr_z,
    input  logic [31:0]        det_threshold,
    input  rduv_pkg::dp_cmd_t  cmd,
    output rduv_pkg::dp_stat_t stat,
    output logic signed [31:0] res [4]
);
    logic signed [31:0] vec_reg [8][3];
    logic [1:0] ax0_reg, ax1_reg;
    logic signed [95:0] acc_reg, den_reg, det_reg;
    logic signed [31:0] t_reg, ox_reg [2], oy_reg [2];
    logic signed [31:0] res_reg [4];
    logic signed [95:0] div_num, div_den;
    logic signed [31:0] quo;
    logic div_busy;
    logic [1:0] res_sel_reg;
    logic pend_reg;

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p;
    endfunction

    function automatic logic signed [95:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return 96'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [95:0] qdot(input logic signed [31:0] a [3],
                                               input logic signed [31:0] b [3]);
        return qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
    endfunction

    logic [31:0] mx, my, mz;
    logic signed [31:0] u0, v0, u1, v1;
    logic signed [95:0] num_c;
    logic signed [31:0] org0, org1, dir0, dir1, hp0, hp1, p0, p1;
    logic signed [95:0] dmag;

    always_comb
    begin
        mx = vec_reg[rduv_pkg::SLOT_NORMAL][0][31] ?
             32'(-vec_reg[rduv_pkg::SLOT_NORMAL][0]) : vec_reg[rduv_pkg::SLOT_NORMAL][0];
        my = vec_reg[rduv_pkg::SLOT_NORMAL][1][31] ?
             32'(-vec_reg[rduv_pkg::SLOT_NORMAL][1]) : vec_reg[rduv_pkg::SLOT_NORMAL][1];
        mz = vec_reg[rduv_pkg::SLOT_NORMAL][2][31] ?
             32'(-vec_reg[rduv_pkg::SLOT_NORMAL][2]) : vec_reg[rduv_pkg::SLOT_NORMAL][2];
        u0 = vec_reg[rduv_pkg::SLOT_DPDU][ax0_reg];
        v0 = vec_reg[rduv_pkg::SLOT_DPDV][ax0_reg];
        u1 = vec_reg[rduv_pkg::SLOT_DPDU][ax1_reg];
        v1 = vec_reg[rduv_pkg::SLOT_DPDV][ax1_reg];
        num_c = '0;
        unique case (cmd.op)
            rduv_pkg::OP_NUM0: num_c = 96'(smul(v1, ox_reg[0])) - 96'(smul(v0, ox_reg[1]));
            rduv_pkg::OP_NUM1: num_c = 96'(smul(u0, ox_reg[1])) - 96'(smul(u1, ox_reg[0]));
            rduv_pkg::OP_NUM2: num_c = 96'(smul(v1, oy_reg[0])) - 96'(smul(v0, oy_reg[1]));
            rduv_pkg::OP_NUM3: num_c = 96'(smul(u0, oy_reg[1])) - 96'(smul(u1, oy_reg[0]));
            default: num_c = '0;
        endcase
        div_num = (cmd.op == rduv_pkg::OP_DIV_X || cmd.op == rduv_pkg::OP_DIV_Y) ?
                  acc_reg : num_c;
        div_den = (cmd.op == rduv_pkg::OP_DIV_X || cmd.op == rduv_pkg::OP_DIV_Y) ?
                  den_reg : det_reg;
        // Offset of a ray hit from the hit point on one selected axis.
        if (cmd.op == rduv_pkg::OP_XP0 || cmd.op == rduv_pkg::OP_XP1)
        begin
            org0 = vec_reg[rduv_pkg::SLOT_XORG][ax0_reg];
            org1 = vec_reg[rduv_pkg::SLOT_XORG][ax1_reg];
            dir0 = vec_reg[rduv_pkg::SLOT_XDIR][ax0_reg];
            dir1 = vec_reg[rduv_pkg::SLOT_XDIR][ax1_reg];
        end
        else
        begin
            org0 = vec_reg[rduv_pkg::SLOT_YORG][ax0_reg];
            org1 = vec_reg[rduv_pkg::SLOT_YORG][ax1_reg];
            dir0 = vec_reg[rduv_pkg::SLOT_YDIR][ax0_reg];
            dir1 = vec_reg[rduv_pkg::SLOT_YDIR][ax1_reg];
        end
        hp0 = vec_reg[rduv_pkg::SLOT_HIT][ax0_reg];
        hp1 = vec_reg[rduv_pkg::SLOT_HIT][ax1_reg];
        p0 = rduv_pkg::sat32(96'(org0) + qmul(dir0, t_reg));
        p1 = rduv_pkg::sat32(96'(org1) + qmul(dir1, t_reg));
        dmag = det_reg[95] ? -det_reg : det_reg;
    end

    rduv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            res_sel_reg <= '0;
        end
        else
        begin
            if (cmd.start_div)
            begin
                pend_reg <= 1'b1;
                unique case (cmd.op)
                    rduv_pkg::OP_NUM1: res_sel_reg <= 2'd1;
                    rduv_pkg::OP_NUM2: res_sel_reg <= 2'd2;
                    rduv_pkg::OP_NUM3: res_sel_reg <= 2'd3;
                    default: res_sel_reg <= 2'd0;
                endcase
            end
            else if (pend_reg && !div_busy)
                pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vec_reg[wr_slot][0] <= wr_x;
            vec_reg[wr_slot][1] <= wr_y;
            vec_reg[wr_slot][2] <= wr_z;
        end
        if (pend_reg && !div_busy)
        begin
            if (cmd.op == rduv_pkg::OP_DIV_X || cmd.op == rduv_pkg::OP_DIV_Y)
                t_reg <= quo;
            else
                res_reg[res_sel_reg] <= quo;
        end
        case (cmd.op)
            rduv_pkg::OP_AXIS:
            begin
                if (mx > my && mx > mz) begin ax0_reg <= 2'd1; ax1_reg <= 2'd2; end
                else if (my > mz)       begin ax0_reg <= 2'd0; ax1_reg <= 2'd2; end
                else                    begin ax0_reg <= 2'd0; ax1_reg <= 2'd1; end
                res_reg[0] <= '0; res_reg[1] <= '0; res_reg[2] <= '0; res_reg[3] <= '0;
            end
            rduv_pkg::OP_ND_HIT, rduv_pkg::OP_ND_HIT2:
                acc_reg <= qdot(vec_reg[rduv_pkg::SLOT_NORMAL], vec_reg[rduv_pkg::SLOT_HIT]);
            rduv_pkg::OP_ND_XORG: acc_reg <= acc_reg -
                qdot(vec_reg[rduv_pkg::SLOT_NORMAL], vec_reg[rduv_pkg::SLOT_XORG]);
            rduv_pkg::OP_ND_YORG: acc_reg <= acc_reg -
                qdot(vec_reg[rduv_pkg::SLOT_NORMAL], vec_reg[rduv_pkg::SLOT_YORG]);
            rduv_pkg::OP_ND_XDIR:
                den_reg <= qdot(vec_reg[rduv_pkg::SLOT_NORMAL], vec_reg[rduv_pkg::SLOT_XDIR]);
            rduv_pkg::OP_ND_YDIR:
                den_reg <= qdot(vec_reg[rduv_pkg::SLOT_NORMAL], vec_reg[rduv_pkg::SLOT_YDIR]);
            rduv_pkg::OP_XP0: ox_reg[0] <= rduv_pkg::sat32(96'(p0) - 96'(hp0));
            rduv_pkg::OP_XP1: ox_reg[1] <= rduv_pkg::sat32(96'(p1) - 96'(hp1));
            rduv_pkg::OP_YP0: oy_reg[0] <= rduv_pkg::sat32(96'(p0) - 96'(hp0));
            rduv_pkg::OP_YP1: oy_reg[1] <= rduv_pkg::sat32(96'(p1) - 96'(hp1));
            rduv_pkg::OP_DET: det_reg <= 96'(smul(u0, v1)) - 96'(smul(v0, u1));
            default: ;
        endcase
    end

    assign stat.div_busy = div_busy || pend_reg;
    assign stat.den_zero = (den_reg == '0);
    assign stat.det_small = (dmag <= 96'(det_threshold));
    assign res = res_reg;
endmodule

/* design/rduv_ctrl.sv */
module rduv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [2:0]         in_slot,
    input  logic               out_ready,
    input  rduv_pkg::dp_stat_t stat,
    output rduv_pkg::dp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid,
    output logic               solved
);
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_t;

    state_t state_reg;
    rduv_pkg::op_t op_reg;
    logic ok_reg;

    always_comb
    begin
        cmd.op = (state_reg == ST_IDLE) ? rduv_pkg::OP_NOP : op_reg;
        cmd.start_div = (state_reg == ST_RUN) &&
            (op_reg == rduv_pkg::OP_DIV_X || op_reg == rduv_pkg::OP_DIV_Y ||
             op_reg == rduv_pkg::OP_NUM0 || op_reg == rduv_pkg::OP_NUM1 ||
             op_reg == rduv_pkg::OP_NUM2 || op_reg == rduv_pkg::OP_NUM3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= rduv_pkg::OP_NOP;
            ok_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_fire && in_slot == rduv_pkg::SLOT_YDIR)
                    begin
                        state_reg <= ST_RUN;
                        op_reg <= rduv_pkg::OP_AXIS;
                        ok_reg <= 1'b1;
                    end
                ST_RUN:
                begin
                    case (op_reg)
                        rduv_pkg::OP_DIV_X, rduv_pkg::OP_DIV_Y, rduv_pkg::OP_NUM0,
                        rduv_pkg::OP_NUM1, rduv_pkg::OP_NUM2, rduv_pkg::OP_NUM3,
                        // den_zero and det_small are sampled in the cycle after the load.
                        rduv_pkg::OP_ND_XDIR, rduv_pkg::OP_ND_YDIR, rduv_pkg::OP_DET:
                            state_reg <= ST_WAIT;
                        default:
                            op_reg <= rduv_pkg::op_t'(op_reg + 1'b1);
                    endcase
                end
                ST_WAIT:
                begin
                    if (op_reg == rduv_pkg::OP_ND_XDIR || op_reg == rduv_pkg::OP_ND_YDIR)
                    begin
                        // A ray parallel to the plane ends the solve without a result.
                        if (stat.den_zero)
                        begin
                            ok_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            op_reg <= rduv_pkg::op_t'(op_reg + 1'b1);
                            state_reg <= ST_RUN;
                        end
                    end
                    else if (op_reg == rduv_pkg::OP_DET)
                    begin
                        if (stat.det_small)
                        begin
                            ok_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            op_reg <= rduv_pkg::OP_NUM0;
                            state_reg <= ST_RUN;
                        end
                    end
                    else if (!stat.div_busy)
                    begin
                        if (op_reg == rduv_pkg::OP_NUM3)
                            state_reg <= ST_DONE;
                        else
                        begin
                            op_reg <= rduv_pkg::op_t'(op_reg + 1'b1);
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_DONE:
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                        op_reg <= rduv_pkg::OP_NOP;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign solved = ok_reg;
endmodule

/* design/ray_differential_uv_solver.sv */
// Ray differential solver. Vectors are written one item per slot; a slot 0..6 write is
// accepted, gives no result and may follow the previous one back to back.
// A slot 7 write starts a solve and closes the input until its one result is taken.
// The solve uses one shared restoring divider six times; a parallel x or y ray ends it
// early, as does a determinant at or below det_threshold. The input reopens the cycle
// after the result is taken. solved=0 results carry zero derivatives. det_threshold is
// written on cfg and should change only between solves.
`include "ray_differential_uv_solver_macros.svh"
module ray_differential_uv_solver #(
    parameter int FRAC_BITS = rduv_pkg::FRAC_BITS_DEF
) (
    input logic   clk,
    input logic   rst_n,
    rduv_in_if.sink   in_ch,
    rduv_out_if.source out_ch,
    rduv_cfg_if.sink  cfg
);
    logic [31:0] det_threshold_reg;
    rduv_pkg::dp_cmd_t cmd;
    rduv_pkg::dp_stat_t stat;
    logic signed [31:0] res [4];
    logic in_fire;
    logic solve_start;
    logic solved;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign solve_start = in_fire && (in_ch.slot == rduv_pkg::SLOT_YDIR);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            det_threshold_reg <= rduv_pkg::DET_THRESHOLD_RST;
        else if (cfg.valid && cfg.ready)
            det_threshold_reg <= cfg.data;
    end

    rduv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_slot   (in_ch.slot),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .solved    (solved)
    );

    rduv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (in_fire),
        .wr_slot       (in_ch.slot),
        .wr_x          (in_ch.comp_x),
        .wr_y          (in_ch.comp_y),
        .wr_z          (in_ch.comp_z),
        .det_threshold (det_threshold_reg),
        .cmd           (cmd),
        .stat          (stat),
        .res           (res)
    );

    assign out_ch.solved = solved;
    assign out_ch.du_dx = solved ? res[0] : '0;
    assign out_ch.dv_dx = solved ? res[1] : '0;
    assign out_ch.du_dy = solved ? res[2] : '0;
    assign out_ch.dv_dy = solved ? res[3] : '0;

    `RDUV_ASSERT_NOW(a_no_in_while_out, clk, rst_n, out_ch.valid, !in_ch.ready, "input open")
    `RDUV_ASSERT_NEXT(a_slot7_starts, clk, rst_n, solve_start, !in_ch.ready, "no solve")
    `RDUV_ASSERT_NOW(a_div_only_busy, clk, rst_n, cmd.start_div, !out_ch.valid, "late divide")
endmodule
